// ----- design/sam_pkg.sv -----
// Package for the sparse accumulator matrix: field widths, parameter defaults,
// operation and status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package sam_pkg;

	// Fixed widths of the transaction fields.
	localparam int KIND_W    = 3;
	localparam int COORD_W   = 6;
	localparam int COORD_N   = 1 << COORD_W;
	localparam int AMT_W     = 32;
	localparam int SLOT_W    = 12;
	localparam int STATUS_W  = 3;
	localparam int CNTOUT_W  = 16;
	localparam int LEN_W     = 13;

	// Defaults for the top-level parameters.
	localparam int DEF_ROWS       = 64;
	localparam int DEF_COLS       = 64;
	localparam int DEF_COUNT_BITS = 16;

	// Operation codes carried in the kind field.
	typedef enum logic [KIND_W-1:0] {
		K_ADD       = 3'd0,
		K_REMOVE    = 3'd1,
		K_CLEAN     = 3'd2,
		K_READ_SLOT = 3'd3,
		K_READ_CELL = 3'd4
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_SLOT  = 3'd2,
		ST_CLAMP = 3'd3,
		ST_LIMIT = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LIST,
		S_CELL,
		S_MOVE1,
		S_MOVE2,
		S_CLEAN
	} state_t;

endpackage

`default_nettype wire

// ----- design/sam_ifs.sv -----
// Valid/ready channel interfaces for the sparse accumulator matrix:
// the request channel and the result channel. Depends on sam_pkg.
`default_nettype none

// Request channel: one operation per transaction.
interface sam_req_if import sam_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [COORD_W-1:0]  row;
	logic [COORD_W-1:0]  col;
	logic [AMT_W-1:0]    amount;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, kind, row, col, amount, slot, input ready);
	modport sink   (input valid, kind, row, col, amount, slot, output ready);
endinterface

// Result channel: one result per request transaction.
interface sam_rsp_if import sam_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COORD_W-1:0]  cell_row;
	logic [COORD_W-1:0]  cell_col;
	logic [AMT_W-1:0]    cell_amount;
	logic [CNTOUT_W-1:0] contributors;
	logic                occupied;
	logic [LEN_W-1:0]    list_length;

	modport source (output valid, status, cell_row, cell_col, cell_amount, contributors,
		occupied, list_length, input ready);
	modport sink   (input valid, status, cell_row, cell_col, cell_amount, contributors,
		occupied, list_length, output ready);
endinterface

`default_nettype wire

// ----- design/sam_cell_store.sv -----
// Cell memory of the sparse accumulator matrix: amount, contributor count and
// list slot per cell, with a zeroing sweep after reset. Depends on sam_pkg.
`default_nettype none

module sam_cell_store import sam_pkg::*; #(
	parameter int DEPTH  = DEF_ROWS * DEF_COLS,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = AMT_W + DEF_COUNT_BITS + ADDR_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	output      logic              init_busy
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              busy_q;
	logic              wr_en_m;
	logic [ADDR_W-1:0] wr_addr_m;
	logic [DATA_W-1:0] wr_data_m;

	// Clearing sweep: one entry per cycle from address zero up after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The sweep owns the write port while it runs.
	always_comb begin
		wr_en_m   = busy_q | wr_en;
		wr_addr_m = busy_q ? clr_q : wr_addr;
		wr_data_m = busy_q ? '0 : wr_data;
	end

	// Synchronous write, registered read; a read of an address written in the
	// same cycle returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en_m) begin
			mem[wr_addr_m] <= wr_data_m;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign init_busy = busy_q;

endmodule

`default_nettype wire

// ----- design/sam_list_store.sv -----
// Occupied-list memory of the sparse accumulator matrix: row and column of the
// cell held in each list slot. Depends on sam_pkg.
`default_nettype none

module sam_list_store import sam_pkg::*; #(
	parameter int DEPTH  = DEF_ROWS * DEF_COLS,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 2 * COORD_W
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Synchronous write, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/sam_ctrl.sv -----
// Sequencer of the sparse accumulator matrix: read-modify-write of the cell
// memory, swap-remove on the list memory, clean walk and the result register.
// Depends on sam_pkg and sam_ifs.
`default_nettype none

module sam_ctrl import sam_pkg::*; #(
	parameter int ROWS       = DEF_ROWS,
	parameter int COLS       = DEF_COLS,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	localparam int CELLS     = ROWS * COLS,
	localparam int IDX_W     = $clog2(CELLS),
	localparam int WORD_W    = AMT_W + COUNT_BITS + IDX_W,
	localparam int LIST_W    = 2 * COORD_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sam_req_if.sink                req,
	sam_rsp_if.source              rsp,
	input  wire logic              init_busy,
	output      logic              cell_rd_en,
	output      logic [IDX_W-1:0]  cell_rd_addr,
	input  wire logic [WORD_W-1:0] cell_rd_data,
	output      logic              cell_wr_en,
	output      logic [IDX_W-1:0]  cell_wr_addr,
	output      logic [WORD_W-1:0] cell_wr_data,
	output      logic              list_rd_en,
	output      logic [IDX_W-1:0]  list_rd_addr,
	input  wire logic [LIST_W-1:0] list_rd_data,
	output      logic              list_wr_en,
	output      logic [IDX_W-1:0]  list_wr_addr,
	output      logic [LIST_W-1:0] list_wr_data
);

	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int CMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

	// Flat cell index of a reduced coordinate pair.
	function automatic logic [IDX_W-1:0] cell_index(input logic [COORD_W-1:0] rr,
		input logic [COORD_W-1:0] cc);
		return IDX_W'(rr) * IDX_W'(COLS) + IDX_W'(cc);
	endfunction

	// Coordinate reduction tables, row modulo ROWS and column modulo COLS.
	logic [COORD_W-1:0] row_tab [COORD_N];
	logic [COORD_W-1:0] col_tab [COORD_N];

	for (genvar i = 0; i < COORD_N; i++) begin : g_mod
		assign row_tab[i] = COORD_W'(i % ROWS);
		assign col_tab[i] = COORD_W'(i % COLS);
	end

	state_t state_q, state_d;

	logic                  accept;
	logic                  out_free;
	logic                  push;
	kind_t                 in_kind;
	logic [COORD_W-1:0]    in_r, in_c;
	logic [IDX_W-1:0]      req_idx;
	logic                  slot_oor;
	logic                  clean_more;
	logic [COORD_W-1:0]    lr, lc;
	logic [IDX_W-1:0]      list_idx;

	// Item registers.
	kind_t                 kind_q;
	logic [COORD_W-1:0]    r_q, c_q;
	logic [AMT_W-1:0]      amt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      hole_q;
	logic [IDX_W-1:0]      mv_idx_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      occ_q;

	// Cell update.
	logic [AMT_W-1:0]      rd_amt;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [IDX_W-1:0]      rd_slot;
	logic [AMT_W:0]        sum_ext;
	logic                  at_limit, was_empty, under;
	logic [AMT_W-1:0]      upd_amt;
	logic [COUNT_BITS-1:0] upd_cnt;
	logic [IDX_W-1:0]      upd_slot;
	status_t               upd_status;
	logic                  cell_write, new_entry, drop_entry;
	logic [CNT_W-1:0]      occ_after;

	// Pending result and output register.
	logic                  res_set;
	logic                  res_pend_q;
	status_t               res_status_q;
	logic [COORD_W-1:0]    res_row_q, res_col_q;
	logic [AMT_W-1:0]      res_amt_q;
	logic [CNTOUT_W-1:0]   res_cnt_q;
	logic                  res_occ_q;
	logic [LEN_W-1:0]      res_len_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [COORD_W-1:0]    out_row_q, out_col_q;
	logic [AMT_W-1:0]      out_amt_q;
	logic [CNTOUT_W-1:0]   out_cnt_q;
	logic                  out_occ_q;
	logic [LEN_W-1:0]      out_len_q;

	// Handshake and request decode.
	assign out_free  = !out_valid_q || rsp.ready;
	assign push      = res_pend_q && out_free;
	assign req.ready = (state_q == S_IDLE) && !init_busy && (!res_pend_q || out_free);
	assign accept    = req.valid && req.ready;
	assign in_kind   = kind_t'(req.kind);
	assign in_r      = row_tab[req.row];
	assign in_c      = col_tab[req.col];
	assign req_idx   = cell_index(in_r, in_c);
	assign slot_oor  = CMP_W'(req.slot) >= CMP_W'(occ_q);
	assign clean_more = ptr_q < occ_q;

	// Memory read words.
	assign lr       = list_rd_data[LIST_W-1:COORD_W];
	assign lc       = list_rd_data[COORD_W-1:0];
	assign list_idx = cell_index(lr, lc);
	assign rd_amt   = cell_rd_data[AMT_W-1:0];
	assign rd_cnt   = cell_rd_data[AMT_W +: COUNT_BITS];
	assign rd_slot  = cell_rd_data[AMT_W + COUNT_BITS +: IDX_W];

	// Saturating add or subtract of the cell just read, with count update.
	always_comb begin
		sum_ext    = {1'b0, rd_amt} + {1'b0, amt_q};
		at_limit   = rd_cnt == '1;
		was_empty  = rd_cnt == '0;
		under      = rd_amt < amt_q;
		upd_amt    = rd_amt;
		upd_cnt    = rd_cnt;
		upd_status = ST_OK;
		cell_write = 1'b0;
		new_entry  = 1'b0;
		drop_entry = 1'b0;
		case (kind_q)
			K_ADD: begin
				if (at_limit) begin
					upd_status = ST_LIMIT;
				end else begin
					cell_write = 1'b1;
					new_entry  = was_empty;
					upd_cnt    = rd_cnt + COUNT_BITS'(1);
					if (sum_ext[AMT_W]) begin
						upd_amt    = '1;
						upd_status = ST_CLAMP;
					end else begin
						upd_amt = sum_ext[AMT_W-1:0];
					end
				end
			end
			K_REMOVE: begin
				if (was_empty) begin
					upd_status = ST_EMPTY;
				end else begin
					cell_write = 1'b1;
					drop_entry = rd_cnt == COUNT_BITS'(1);
					upd_cnt    = rd_cnt - COUNT_BITS'(1);
					if (under) begin
						upd_amt    = '0;
						upd_status = ST_CLAMP;
					end else begin
						upd_amt = rd_amt - amt_q;
					end
					// The last contributor leaves the cell at zero.
					if (drop_entry) begin
						upd_amt = '0;
					end
				end
			end
			default: ;
		endcase
		upd_slot = new_entry ? IDX_W'(occ_q) : rd_slot;
		if (new_entry) begin
			occ_after = occ_q + CNT_W'(1);
		end else if (drop_entry) begin
			occ_after = occ_q - CNT_W'(1);
		end else begin
			occ_after = occ_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_kind) inside
						K_ADD, K_REMOVE, K_READ_CELL: state_d = S_CELL;
						K_READ_SLOT: if (!slot_oor) state_d = S_LIST;
						K_CLEAN: if (occ_q != '0) state_d = S_CLEAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LIST:  state_d = S_CELL;
			S_CELL:  state_d = drop_entry ? S_MOVE1 : S_IDLE;
			S_MOVE1: state_d = S_MOVE2;
			S_MOVE2: state_d = S_IDLE;
			S_CLEAN: if (!clean_more) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory requests and result completion per state.
	always_comb begin
		cell_rd_en   = 1'b0;
		cell_rd_addr = req_idx;
		cell_wr_en   = 1'b0;
		cell_wr_addr = idx_q;
		cell_wr_data = {upd_slot, upd_cnt, upd_amt};
		list_rd_en   = 1'b0;
		list_rd_addr = IDX_W'(req.slot);
		list_wr_en   = 1'b0;
		list_wr_addr = IDX_W'(occ_q);
		list_wr_data = {r_q, c_q};
		res_set      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_kind) inside
						K_ADD, K_REMOVE, K_READ_CELL: cell_rd_en = 1'b1;
						K_READ_SLOT: begin
							if (slot_oor) begin
								res_set = 1'b1;
							end else begin
								list_rd_en = 1'b1;
							end
						end
						K_CLEAN: begin
							if (occ_q == '0) begin
								res_set = 1'b1;
							end else begin
								list_rd_en   = 1'b1;
								list_rd_addr = '0;
							end
						end
						default: res_set = 1'b1;
					endcase
				end
			end
			S_LIST: begin
				cell_rd_en   = 1'b1;
				cell_rd_addr = list_idx;
			end
			S_CELL: begin
				cell_wr_en   = cell_write;
				list_wr_en   = new_entry;
				// Fetch the last list entry to move it into the freed slot.
				list_rd_en   = drop_entry;
				list_rd_addr = IDX_W'(occ_q - CNT_W'(1));
				res_set      = !drop_entry;
			end
			S_MOVE1: begin
				list_wr_en   = 1'b1;
				list_wr_addr = hole_q;
				list_wr_data = list_rd_data;
				cell_rd_en   = 1'b1;
				cell_rd_addr = list_idx;
			end
			S_MOVE2: begin
				cell_wr_en   = 1'b1;
				cell_wr_addr = mv_idx_q;
				cell_wr_data = {hole_q, rd_cnt, rd_amt};
				res_set      = 1'b1;
			end
			S_CLEAN: begin
				cell_wr_en   = 1'b1;
				cell_wr_addr = list_idx;
				cell_wr_data = '0;
				if (clean_more) begin
					list_rd_en   = 1'b1;
					list_rd_addr = IDX_W'(ptr_q);
				end else begin
					res_set = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			ptr_q       <= '0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				res_pend_q <= 1'b1;
			end else if (push) begin
				res_pend_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (accept) ptr_q <= CNT_W'(1);
				S_CELL:  occ_q <= occ_after;
				S_CLEAN: begin
					if (clean_more) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else begin
						occ_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Item, pending result and output payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= in_kind;
					r_q    <= in_r;
					c_q    <= in_c;
					amt_q  <= req.amount;
					idx_q  <= req_idx;
				end
				// Results that need no memory access.
				if (res_set) begin
					res_status_q <= (in_kind == K_READ_SLOT) ? ST_SLOT : ST_OK;
					res_row_q    <= '0;
					res_col_q    <= '0;
					res_amt_q    <= '0;
					res_cnt_q    <= '0;
					res_occ_q    <= 1'b0;
					res_len_q    <= LEN_W'(occ_q);
				end
			end
			S_LIST: begin
				r_q   <= lr;
				c_q   <= lc;
				idx_q <= list_idx;
			end
			S_CELL: begin
				hole_q       <= rd_slot;
				res_status_q <= upd_status;
				res_row_q    <= r_q;
				res_col_q    <= c_q;
				res_amt_q    <= upd_amt;
				res_cnt_q    <= CNTOUT_W'(upd_cnt);
				res_occ_q    <= upd_cnt != '0;
				res_len_q    <= LEN_W'(occ_after);
			end
			S_MOVE1: mv_idx_q <= list_idx;
			S_CLEAN: begin
				if (!clean_more) begin
					res_status_q <= ST_OK;
					res_row_q    <= '0;
					res_col_q    <= '0;
					res_amt_q    <= '0;
					res_cnt_q    <= '0;
					res_occ_q    <= 1'b0;
					res_len_q    <= '0;
				end
			end
			default: ;
		endcase
		if (push) begin
			out_status_q <= res_status_q;
			out_row_q    <= res_row_q;
			out_col_q    <= res_col_q;
			out_amt_q    <= res_amt_q;
			out_cnt_q    <= res_cnt_q;
			out_occ_q    <= res_occ_q;
			out_len_q    <= res_len_q;
		end
	end

	// Result channel.
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.cell_row     = out_row_q;
	assign rsp.cell_col     = out_col_q;
	assign rsp.cell_amount  = out_amt_q;
	assign rsp.contributors = out_cnt_q;
	assign rsp.occupied     = out_occ_q;
	assign rsp.list_length  = out_len_q;

endmodule

`default_nettype wire

// ----- design/sparse_accumulator_matrix.sv -----
// Sparse accumulator matrix: ROWS x COLS cells of 16.16 amounts with contributor
// counts and a dense list of occupied cells. Add and remove read the cell memory,
// then write it back; read cell only reads it; read list slot reads the list first;
// a remove that empties its cell also moves the last list entry into the hole and
// rewrites the moved cell; clean zeroes each listed cell; other kinds need no memory
// access. A result passes through a pending register, then the output register.
// After reset, ready stays low while the cell memory is zeroed, one entry per cycle.
`default_nettype none

module sparse_accumulator_matrix import sam_pkg::*; #(
	parameter int ROWS       = DEF_ROWS,
	parameter int COLS       = DEF_COLS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sam_req_if.sink   req,
	sam_rsp_if.source rsp
);

	localparam int CELLS  = ROWS * COLS;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int WORD_W = AMT_W + COUNT_BITS + IDX_W;
	localparam int LIST_W = 2 * COORD_W;

	logic              init_busy;
	logic              cell_rd_en, cell_wr_en;
	logic [IDX_W-1:0]  cell_rd_addr, cell_wr_addr;
	logic [WORD_W-1:0] cell_rd_data, cell_wr_data;
	logic              list_rd_en, list_wr_en;
	logic [IDX_W-1:0]  list_rd_addr, list_wr_addr;
	logic [LIST_W-1:0] list_rd_data, list_wr_data;

	// Sequencer.
	sam_ctrl #(
		.ROWS       (ROWS),
		.COLS       (COLS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.init_busy    (init_busy),
		.cell_rd_en   (cell_rd_en),
		.cell_rd_addr (cell_rd_addr),
		.cell_rd_data (cell_rd_data),
		.cell_wr_en   (cell_wr_en),
		.cell_wr_addr (cell_wr_addr),
		.cell_wr_data (cell_wr_data),
		.list_rd_en   (list_rd_en),
		.list_rd_addr (list_rd_addr),
		.list_rd_data (list_rd_data),
		.list_wr_en   (list_wr_en),
		.list_wr_addr (list_wr_addr),
		.list_wr_data (list_wr_data)
	);

	// Cell memory with the reset sweep.
	sam_cell_store #(
		.DEPTH  (CELLS),
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (cell_rd_en),
		.rd_addr   (cell_rd_addr),
		.rd_data   (cell_rd_data),
		.wr_en     (cell_wr_en),
		.wr_addr   (cell_wr_addr),
		.wr_data   (cell_wr_data),
		.init_busy (init_busy)
	);

	// Occupied-list memory.
	sam_list_store #(
		.DEPTH  (CELLS),
		.ADDR_W (IDX_W),
		.DATA_W (LIST_W)
	) u_list (
		.clk     (clk),
		.rd_en   (list_rd_en),
		.rd_addr (list_rd_addr),
		.rd_data (list_rd_data),
		.wr_en   (list_wr_en),
		.wr_addr (list_wr_addr),
		.wr_data (list_wr_data)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sparse_accumulator_matrix: directed, busy-cell,
// list-fill and random transactions with a cycle-free predictor of the cell matrix
// and its occupied list. Depends on sam_pkg, sam_ifs.sv and the block itself.

module tb_top;
	import sam_pkg::*;

	localparam int ROWS       = DEF_ROWS;
	localparam int COLS       = DEF_COLS;
	localparam int COUNT_BITS = DEF_COUNT_BITS;
	localparam int CELLS      = ROWS * COLS;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam logic [KIND_W-1:0] KIND_TOP = KIND_W'((1 << KIND_W) - 1);
	localparam longint LIMIT_NS = 2_000_000;
	localparam int IDLE_PCT = 12;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [AMT_W-1:0]   amount;
		logic [SLOT_W-1:0]  slot;
	} sam_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COORD_W-1:0]  cell_row;
		logic [COORD_W-1:0]  cell_col;
		logic [AMT_W-1:0]    cell_amount;
		logic [CNTOUT_W-1:0] contributors;
		logic                occupied;
		logic [LEN_W-1:0]    list_length;
	} sam_res_t;

	logic clk;
	logic arst_n;
	bit   no_idle;

	sam_req_if req_if ();
	sam_rsp_if rsp_if ();

	sparse_accumulator_matrix dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Predicted contents of the matrix and of the dense occupied list.
	logic [AMT_W-1:0]   acc_amount [CELLS];
	int unsigned        acc_count  [CELLS];
	int unsigned        acc_slot   [CELLS];
	logic [COORD_W-1:0] walk_row   [CELLS];
	logic [COORD_W-1:0] walk_col   [CELLS];
	int unsigned        walk_len;
	int unsigned        peak_len;

	sam_res_t    pending_results [$];
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned mismatch_count;
	int unsigned status_hits [8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#LIMIT_NS;
		$display("tb_top: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string field, input logic [AMT_W-1:0] got,
		input logic [AMT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
				n_checked, field, got, want));
	endtask

	function automatic sam_op_t make_op(input logic [KIND_W-1:0] kind,
		input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
		input logic [AMT_W-1:0] amount, input logic [SLOT_W-1:0] slot);
		sam_op_t op;
		op.kind   = kind;
		op.row    = row;
		op.col    = col;
		op.amount = amount;
		op.slot   = slot;
		return op;
	endfunction

	// Amounts biased toward the saturation edges and the fractional part.
	function automatic logic [AMT_W-1:0] pick_amount();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return AMT_W'($urandom_range(16'hFFFF));
			3: return {AMT_W'($urandom_range(8'hFF))} << 16;
			4: return AMT_W'($urandom) & 32'h000F_FFFF;
			default: return AMT_W'($urandom);
		endcase
	endfunction

	// View of one cell as the block reports it.
	function automatic sam_res_t cell_view(input logic [STATUS_W-1:0] st,
		input int unsigned rr, input int unsigned cc);
		sam_res_t v;
		int unsigned idx;
		idx = rr * COLS + cc;
		v.status       = st;
		v.cell_row     = COORD_W'(rr);
		v.cell_col     = COORD_W'(cc);
		v.cell_amount  = acc_amount[idx];
		v.contributors = CNTOUT_W'(acc_count[idx]);
		v.occupied     = (acc_count[idx] != 0);
		v.list_length  = LEN_W'(walk_len);
		return v;
	endfunction

	// Applies one operation to the predicted state and returns the expected result.
	function automatic sam_res_t matrix_apply(input sam_op_t op);
		sam_res_t res;
		int unsigned rr, cc, idx, hole, last, lr, lc;
		logic [AMT_W:0] wide;
		logic [STATUS_W-1:0] st;
		rr  = op.row % ROWS;
		cc  = op.col % COLS;
		idx = rr * COLS + cc;
		st  = ST_OK;
		res = '0;
		case (op.kind)
			K_ADD: begin
				if (acc_count[idx] >= COUNT_MAX) begin
					st = ST_LIMIT;
				end else begin
					wide = {1'b0, acc_amount[idx]} + {1'b0, op.amount};
					if (wide[AMT_W]) begin
						acc_amount[idx] = '1;
						st = ST_CLAMP;
					end else begin
						acc_amount[idx] = wide[AMT_W-1:0];
					end
					acc_count[idx]++;
					// The first contributor appends the cell to the list.
					if (acc_count[idx] == 1 && walk_len < CELLS) begin
						walk_row[walk_len] = COORD_W'(rr);
						walk_col[walk_len] = COORD_W'(cc);
						acc_slot[idx] = walk_len;
						walk_len++;
					end
				end
				res = cell_view(st, rr, cc);
			end
			K_REMOVE: begin
				if (acc_count[idx] == 0) begin
					st = ST_EMPTY;
				end else begin
					if (acc_amount[idx] < op.amount) begin
						acc_amount[idx] = '0;
						st = ST_CLAMP;
					end else begin
						acc_amount[idx] = acc_amount[idx] - op.amount;
					end
					acc_count[idx]--;
					// Last contributor gone: zero the cell and move the tail entry into its slot.
					if (acc_count[idx] == 0) begin
						acc_amount[idx] = '0;
						if (walk_len > 0) begin
							hole = acc_slot[idx] % CELLS;
							last = walk_len - 1;
							lr = walk_row[last] % ROWS;
							lc = walk_col[last] % COLS;
							walk_row[hole] = COORD_W'(lr);
							walk_col[hole] = COORD_W'(lc);
							acc_slot[lr * COLS + lc] = hole;
							walk_len = last;
						end
					end
				end
				res = cell_view(st, rr, cc);
			end
			K_CLEAN: begin
				for (int i = 0; i < walk_len; i++) begin
					acc_amount[(walk_row[i] % ROWS) * COLS + (walk_col[i] % COLS)] = '0;
					acc_count[(walk_row[i] % ROWS) * COLS + (walk_col[i] % COLS)] = 0;
				end
				walk_len = 0;
			end
			K_READ_SLOT: begin
				if (op.slot >= walk_len)
					res.status = ST_SLOT;
				else
					res = cell_view(ST_OK, walk_row[op.slot] % ROWS, walk_col[op.slot] % COLS);
			end
			K_READ_CELL: begin
				res = cell_view(ST_OK, rr, cc);
			end
			default: begin
			end
		endcase
		res.list_length = LEN_W'(walk_len);
		if (walk_len > peak_len)
			peak_len = walk_len;
		return res;
	endfunction

	// Offers one transaction, with random gaps, and records its expected result once accepted.
	task automatic send_op(input sam_op_t op);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid  <= 1'b1;
		req_if.kind   <= op.kind;
		req_if.row    <= op.row;
		req_if.col    <= op.col;
		req_if.amount <= op.amount;
		req_if.slot   <= op.slot;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pending_results.push_back(matrix_apply(op));
		n_sent++;
	endtask

	// Stops offering and waits until every expected result has been seen.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random backpressure and field-by-field comparison.
	always @(posedge clk) begin
		sam_res_t want;
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d",
					rsp_if.status));
			end else begin
				want = pending_results.pop_front();
				compare_field("status", AMT_W'(rsp_if.status), AMT_W'(want.status));
				compare_field("cell_row", AMT_W'(rsp_if.cell_row), AMT_W'(want.cell_row));
				compare_field("cell_col", AMT_W'(rsp_if.cell_col), AMT_W'(want.cell_col));
				compare_field("cell_amount", rsp_if.cell_amount, want.cell_amount);
				compare_field("contributors", AMT_W'(rsp_if.contributors),
					AMT_W'(want.contributors));
				compare_field("occupied", AMT_W'(rsp_if.occupied), AMT_W'(want.occupied));
				compare_field("list_length", AMT_W'(rsp_if.list_length),
					AMT_W'(want.list_length));
				status_hits[want.status]++;
			end
			n_checked++;
		end
		rsp_if.ready <= arst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
	end

	// Field extremes, every operation and the listed corner cases.
	task automatic test_directed();
		send_op(make_op(K_READ_CELL, 0, 0, 0, 0));
		send_op(make_op(K_REMOVE, 63, 63, 5, 0));
		send_op(make_op(K_ADD, 0, 0, '1, '1));
		send_op(make_op(K_ADD, 0, 0, 1, 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 0));
		send_op(make_op(K_READ_SLOT, '1, '1, '1, 1));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, '1));
		send_op(make_op(K_ADD, 63, 63, 32'h0001_8000, 0));
		send_op(make_op(K_ADD, 5, 9, 0, 0));
		send_op(make_op(K_REMOVE, 0, 0, '1, 0));
		// Underflow on the last contributor; the tail entry fills the freed slot.
		send_op(make_op(K_REMOVE, 0, 0, 5, 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 2));
		send_op(make_op(K_ADD, 63, 63, 32'h0002_0000, 0));
		send_op(make_op(K_REMOVE, 63, 63, 32'h0001_0000, 0));
		// Residual amount is dropped when the last contributor leaves.
		send_op(make_op(K_REMOVE, 63, 63, 1, 0));
		send_op(make_op(K_READ_CELL, 63, 63, 0, 0));
		for (int k = K_READ_CELL + 1; k <= KIND_TOP; k++)
			send_op(make_op(KIND_W'(k), COORD_W'($urandom), COORD_W'($urandom),
				AMT_W'($urandom), SLOT_W'($urandom)));
		send_op(make_op(K_CLEAN, '1, '1, '1, '1));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 0));
		send_op(make_op(K_READ_CELL, 5, 9, 0, 0));
		send_op(make_op(K_REMOVE, 5, 9, 0, 0));
	endtask

	// Piles contributors onto one cell back to back, strips them again, then drains.
	task automatic test_busy_cell();
		logic [COORD_W-1:0] r, c;
		r = COORD_W'($urandom);
		c = COORD_W'($urandom);
		no_idle = 1'b1;
		for (int i = 0; i < 30; i++)
			send_op(make_op(K_ADD, r, c, AMT_W'($urandom_range(16'hFFFF)), 0));
		send_op(make_op(K_READ_CELL, r, c, 0, 0));
		for (int i = 0; i < 31; i++)
			send_op(make_op(K_REMOVE, r, c, pick_amount(), 0));
		send_op(make_op(K_READ_CELL, r, c, 0, 0));
		no_idle = 1'b0;
		drain_results();
	endtask

	// Fills two rows of cells, then removes from the middle of the list and cleans.
	task automatic test_list_fill();
		send_op(make_op(K_CLEAN, 0, 0, 0, 0));
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < COLS; c++)
				send_op(make_op(K_ADD, COORD_W'(r), COORD_W'(c), pick_amount(), 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, '1));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 0));
		send_op(make_op(K_ADD, 31, 17, pick_amount(), 0));
		for (int k = 0; k < 3; k++)
			send_op(make_op(K_REMOVE, COORD_W'($urandom_range(1)), COORD_W'($urandom),
				pick_amount(), 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, '1));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, SLOT_W'($urandom_range(walk_len - 1))));
		send_op(make_op(K_CLEAN, 0, 0, 0, 0));
		send_op(make_op(K_READ_SLOT, 0, 0, 0, 0));
	endtask

	// Random mix centered on a small set of busy cells so removes empty them often.
	task automatic test_random_mix(input int unsigned n_ops);
		logic [COORD_W-1:0] busy_r [16];
		logic [COORD_W-1:0] busy_c [16];
		logic [COORD_W-1:0] r, c;
		logic [SLOT_W-1:0]  s;
		int unsigned        pick, h;
		for (int i = 0; i < 16; i++) begin
			busy_r[i] = COORD_W'($urandom);
			busy_c[i] = COORD_W'($urandom);
		end
		for (int unsigned i = 0; i < n_ops; i++) begin
			if (i == n_ops / 2)
				drain_results();
			h = $urandom_range(15);
			if ($urandom_range(99) < 80) begin
				r = busy_r[h];
				c = busy_c[h];
			end else begin
				r = COORD_W'($urandom);
				c = COORD_W'($urandom);
			end
			if (walk_len > 0 && $urandom_range(9) < 8)
				s = SLOT_W'($urandom_range(walk_len - 1));
			else
				s = SLOT_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 40)
				send_op(make_op(K_ADD, r, c, pick_amount(), s));
			else if (pick < 68)
				send_op(make_op(K_REMOVE, r, c, pick_amount(), s));
			else if (pick < 80)
				send_op(make_op(K_READ_SLOT, r, c, pick_amount(), s));
			else if (pick < 95)
				send_op(make_op(K_READ_CELL, r, c, pick_amount(), s));
			else if (pick < 98)
				send_op(make_op(KIND_W'($urandom_range(KIND_TOP, K_READ_CELL + 1)),
					r, c, pick_amount(), s));
			else
				send_op(make_op(K_CLEAN, r, c, pick_amount(), s));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		no_idle       = 1'b0;
		req_if.valid  = 1'b0;
		req_if.kind   = K_READ_CELL;
		req_if.row    = '0;
		req_if.col    = '0;
		req_if.amount = '0;
		req_if.slot   = '0;
		for (int i = 0; i < CELLS; i++) begin
			acc_amount[i] = '0;
			acc_count[i]  = 0;
			acc_slot[i]   = 0;
			walk_row[i]   = '0;
			walk_col[i]   = '0;
		end
		walk_len = 0;
		peak_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_busy_cell();
		test_list_fill();
		test_random_mix(480);

		drain_results();
		repeat (20) @(posedge clk);
		$display("summary: %0d transactions sent, %0d results checked, longest list %0d",
			n_sent, n_checked, peak_len);
		$display("summary: clamps %0d, empty removes %0d, slot misses %0d, count limit %0d",
			status_hits[ST_CLAMP], status_hits[ST_EMPTY], status_hits[ST_SLOT],
			status_hits[ST_LIMIT]);
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
